/* design/mmlm_pkg.sv */
// Shared constants, types and elaboration-time helpers for the multitrack
// mixer with level meter. No dependencies.
package mmlm_pkg;

   localparam int NUM_TRACKS = 4;
   localparam int WINDOW_LEN = 1470;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int PROD_A_W   = SAMPLE_W + GAIN_W;
   localparam int PROD_B_W   = PROD_A_W + GAIN_W;
   localparam int GAIN_SHIFT = 30;
   localparam int TERM_W     = PROD_B_W - GAIN_SHIFT + 1;
   localparam int TOTAL_W    = TERM_W + $clog2(NUM_TRACKS);
   localparam int SQ_W       = 2 * SAMPLE_W - 1;
   localparam int SUM_W      = 42;
   localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
   localparam int DB_W       = 13;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE   = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

   // log2 in Q16: 6 integer bits, 16 fraction bits
   localparam int P_W    = 6;
   localparam int FRAC_W = 16;
   localparam int L2_W   = P_W + FRAC_W;
   localparam int MANT_W = 31;
   localparam int NEG_W  = 22;
   localparam int DBK_W  = 22;
   localparam int DBP_W  = NEG_W + DBK_W;

   localparam logic [DBK_W-1:0] DB_PER_LOG2_Q16 = 22'd3156528;
   localparam logic [11:0] LEVEL_MAG_MAX = 12'd3200;
   localparam logic signed [DB_W-1:0] LEVEL_FLOOR = -13'sd3200;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic signed [TERM_W-1:0]   term_type;
   typedef logic signed [DB_W-1:0]     db_type;

   // load enables for a pair of consecutive stages
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_en_type;

   // bit-exact log2 in Q16, used only at elaboration
   function automatic logic [L2_W-1:0] log2_q16(input logic [63:0] x);
      logic [P_W-1:0]    p;
      logic [63:0]       m;
      logic [FRAC_W-1:0] frac;
      p = '0;
      for (int b = 1; b < 64; b++) begin
         if (x[b]) p = P_W'(b);
      end
      if (p >= P_W'(30)) m = x >> (p - P_W'(30));
      else m = x << (P_W'(30) - p);
      frac = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         m = (m * m) >> 30;
         frac = {frac[FRAC_W-2:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return {p, frac};
   endfunction

   // log2 of the window length plus the Q30 scale of a full-scale square
   localparam logic [NEG_W-1:0] LOG_OFFSET =
      NEG_W'(log2_q16(64'(WINDOW_LEN))) + NEG_W'(30 * 65536);

endpackage

/* design/mmlm_if.sv */
// Request and response channel interfaces of the mixer.
// Depends on mmlm_pkg.
interface mmlm_req_if import mmlm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type track0_sample;
   sample_type track1_sample;
   sample_type track2_sample;
   sample_type track3_sample;

   modport source (output valid, track0_sample, track1_sample, track2_sample,
                   track3_sample, input ready);
   modport sink (input valid, track0_sample, track1_sample, track2_sample,
                 track3_sample, output ready);
endinterface

interface mmlm_rsp_if import mmlm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type mixed_sample;
   logic       level_valid;
   db_type     level_db;

   modport source (output valid, mixed_sample, level_valid, level_db, input ready);
   modport sink (input valid, mixed_sample, level_valid, level_db, output ready);
endinterface

/* design/mmlm_lane.sv */
// One track lane: sample times track gain, then times master gain, >> 30.
// Depends on mmlm_pkg.
module mmlm_lane import mmlm_pkg::*; (
   input  logic         clock,
   input  stage_en_type en,
   input  sample_type   sample,
   input  gain_type     gain,
   input  gain_type     master,
   input  logic         mute,
   output term_type     term
);

   logic [SAMPLE_W:0]   ext;
   logic [SAMPLE_W:0]   mag;
   logic [PROD_A_W-1:0] prod_a_in, prod_a_ff;
   logic                neg_ff, mute_ff;
   logic [PROD_B_W-1:0] prod_b;
   logic [TERM_W-2:0]   mag_term;
   term_type            term_in, term_ff;

   // magnitude; the most negative sample still fits unsigned
   assign ext       = {sample[SAMPLE_W-1], sample};
   assign mag       = sample[SAMPLE_W-1] ? (~ext + 1'b1) : ext;
   assign prod_a_in = mag[SAMPLE_W-1:0] * gain;

   assign prod_b   = PROD_B_W'(prod_a_ff) * PROD_B_W'(master);
   assign mag_term = prod_b[PROD_B_W-1:GAIN_SHIFT];

   always_comb begin
      if (mute_ff) term_in = '0;
      else if (neg_ff) term_in = -$signed({1'b0, mag_term});
      else term_in = $signed({1'b0, mag_term});
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         prod_a_ff <= prod_a_in;
         neg_ff    <= sample[SAMPLE_W-1];
         mute_ff   <= mute;
      end
      if (en.load_b) term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

/* design/mmlm_mix.sv */
// Merge stage: adds the lane terms, saturates to 16 bits, then squares.
// Depends on mmlm_pkg.
module mmlm_mix import mmlm_pkg::*; (
   input  logic             clock,
   input  stage_en_type     en,
   input  term_type         terms [NUM_TRACKS],
   output sample_type       total,
   output logic [SQ_W-1:0]  square
);

   logic signed [TOTAL_W-1:0] sum;
   sample_type                sat_in, sat_ff, total_ff;
   logic [2*SAMPLE_W-1:0]     sq_full;
   logic [SQ_W-1:0]           sq_ff;

   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_TRACKS; i++) begin
         sum = sum + TOTAL_W'(terms[i]);
      end
      if (sum > TOTAL_W'(32767)) sat_in = 16'sh7fff;
      else if (sum < -TOTAL_W'(32768)) sat_in = -16'sh8000;
      else sat_in = sum[SAMPLE_W-1:0];
   end

   // full-width signed square; never negative, at most 2^30
   assign sq_full = (2*SAMPLE_W)'(sat_ff) * (2*SAMPLE_W)'(sat_ff);

   always_ff @(posedge clock) begin
      if (en.load_a) sat_ff <= sat_in;
      if (en.load_b) begin
         total_ff <= sat_ff;
         sq_ff    <= sq_full[SQ_W-1:0];
      end
   end

   assign total  = total_ff;
   assign square = sq_ff;

endmodule

/* design/mmlm_level.sv */
// Window level: normalise, 16 squaring rounds of log2, scale to 1/16 dB.
// Depends on mmlm_pkg.
module mmlm_level import mmlm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] sum,
   output logic             busy,
   output db_type           db
);

   typedef enum logic [2:0] {IDLE, NORM, ROUND, SUBT, MULT, FIN} state_type;

   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   x_ff, x_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [MANT_W-1:0]  m_ff, m_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [3:0]         round_ff, round_in;
   logic [NEG_W-1:0]   neg_ff, neg_in;
   logic [DBP_W-1:0]   prod_ff, prod_in;
   db_type             db_ff, db_in;
   logic [2*MANT_W-1:0] sq;
   logic signed [NEG_W:0] diff;
   logic [DBP_W-1:0]   rnd;
   logic [DBP_W-17:0]  magw;
   logic [11:0]        mag;

   assign sq   = m_ff * m_ff;
   assign diff = $signed({1'b0, LOG_OFFSET}) - $signed({1'b0, p_ff, frac_ff});
   assign rnd  = prod_ff + DBP_W'(32768);
   assign magw = rnd[DBP_W-1:16];
   assign mag  = (magw > (DBP_W-16)'(LEVEL_MAG_MAX)) ? LEVEL_MAG_MAX : magw[11:0];

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      round_in = round_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      db_in    = db_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               if (sum == '0) begin
                  db_in = LEVEL_FLOOR;     // silent window
               end else begin
                  x_in     = sum;
                  p_in     = P_W'(SUM_W - 1);
                  state_in = NORM;
               end
            end
         end
         NORM: begin
            if (x_ff[SUM_W-1]) begin
               m_in     = x_ff[SUM_W-1 -: MANT_W];
               frac_in  = '0;
               round_in = '0;
               state_in = ROUND;
            end else begin
               x_in = {x_ff[SUM_W-2:0], 1'b0};
               p_in = p_ff - 1'b1;
            end
         end
         ROUND: begin
            frac_in  = {frac_ff[FRAC_W-2:0], sq[2*MANT_W-1]};
            m_in     = sq[2*MANT_W-1] ? sq[2*MANT_W-1 -: MANT_W] : sq[2*MANT_W-2 -: MANT_W];
            round_in = round_ff + 1'b1;
            if (round_ff == 4'hf) state_in = SUBT;
         end
         SUBT: begin
            // louder than full scale clamps to 0 dB
            neg_in   = diff[NEG_W] ? '0 : diff[NEG_W-1:0];
            state_in = MULT;
         end
         MULT: begin
            prod_in  = neg_ff * DB_PER_LOG2_Q16;
            state_in = FIN;
         end
         FIN: begin
            db_in    = DB_W'(0) - DB_W'(mag);
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
      x_ff     <= x_in;
      p_ff     <= p_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      round_ff <= round_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      db_ff    <= db_in;
   end

   assign busy = (state_ff != IDLE);
   assign db   = db_ff;

endmodule

/* design/multitrack_mixer_level_meter.sv */
// Top level of the four-track mixer with windowed RMS level meter.
// Depends on mmlm_pkg, mmlm_if, mmlm_lane, mmlm_mix and mmlm_level.
//
// Usage:
//  - req_ch carries one item of four signed 16-bit track samples; rsp_ch
//    returns one item per request: the saturated mix, a window flag and the
//    window level in 1/16 dB (0 when no window closes).
//  - csr_* writes gains, master gain and mute mask; write only when idle.
//  - Pipeline: two lane stages, a merge stage (sum and saturate), a square
//    stage and the output register, which drives rsp_ch.valid.
//  - Throughput is one item per cycle while rsp_ch.ready stays high and no
//    level is being computed. The item that closes each window of 1470
//    waits in the output register for the level unit: not at all for a
//    silent window, else while it normalises (one bit a cycle), runs 16
//    squaring rounds and then the SUBT, MULT and FIN steps. The pipeline
//    holds behind it meanwhile.
//  - Each stage has its own valid bit, so bubbles collapse: when the
//    receiver stalls, items keep being accepted until all stages are full.
//  - Reset (synchronous, active high) restores unity gains, clears mute,
//    empties the pipeline and starts a fresh meter window.
module multitrack_mixer_level_meter import mmlm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mmlm_req_if.sink              req_ch,
   mmlm_rsp_if.source            rsp_ch
);

   // configuration registers
   gain_type              gain_ff [NUM_TRACKS];
   gain_type              master_ff;
   logic [NUM_TRACKS-1:0] mute_ff;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   logic free1, free2, free3, free4, out_free;
   logic rsp_fire, mv4;
   stage_en_type lane_en, mix_en;

   sample_type samples [NUM_TRACKS];
   term_type   terms   [NUM_TRACKS];
   sample_type total4;
   logic [SQ_W-1:0] sq4;

   // meter window
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             close;

   // output register
   sample_type out_mixed_ff;
   logic       out_lvalid_ff;

   logic   lvl_start, lvl_busy;
   db_type lvl_db;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TRACKS; i++) gain_ff[i] <= GAIN_UNITY;
         master_ff <= GAIN_UNITY;
         mute_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN0:  gain_ff[0] <= csr_wdata;
            CSR_GAIN1:  gain_ff[1] <= csr_wdata;
            CSR_GAIN2:  gain_ff[2] <= csr_wdata;
            CSR_GAIN3:  gain_ff[3] <= csr_wdata;
            CSR_MASTER: master_ff  <= csr_wdata;
            CSR_MUTE:   mute_ff    <= csr_wdata[NUM_TRACKS-1:0];
            default: ;  // unknown index: ignored
         endcase
      end
   end

   // a stage may load when it is empty or its contents move on
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign out_free = !out_v_ff || rsp_fire;
   assign free4    = !v4_ff || out_free;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign mv4      = v4_ff && out_free;

   assign req_ch.ready = free1;

   assign lane_en.load_a = free1;
   assign lane_en.load_b = free2;
   assign mix_en.load_a  = free3;
   assign mix_en.load_b  = free4;

   assign samples[0] = req_ch.track0_sample;
   assign samples[1] = req_ch.track1_sample;
   assign samples[2] = req_ch.track2_sample;
   assign samples[3] = req_ch.track3_sample;

   for (genvar t = 0; t < NUM_TRACKS; t++) begin : g_lane
      mmlm_lane u_lane (
         .clock  (clock),
         .en     (lane_en),
         .sample (samples[t]),
         .gain   (gain_ff[t]),
         .master (master_ff),
         .mute   (mute_ff[t]),
         .term   (terms[t])
      );
   end

   mmlm_mix u_mix (
      .clock  (clock),
      .en     (mix_en),
      .terms  (terms),
      .total  (total4),
      .square (sq4)
   );

   // window accumulation as an item leaves the square stage
   assign sum_in    = sum_ff + SUM_W'(sq4);
   assign count_in  = count_ff + 1'b1;
   assign close     = (count_in == CNT_W'(WINDOW_LEN));
   assign lvl_start = mv4 && close;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (free1)    v1_ff    <= req_ch.valid;
         if (free2)    v2_ff    <= v1_ff;
         if (free3)    v3_ff    <= v2_ff;
         if (free4)    v4_ff    <= v3_ff;
         if (out_free) out_v_ff <= v4_ff;
         if (mv4) begin
            sum_ff   <= close ? '0 : sum_in;
            count_ff <= close ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mv4) begin
         out_mixed_ff  <= total4;
         out_lvalid_ff <= close;
      end
   end

   mmlm_level u_level (
      .clock (clock),
      .reset (reset),
      .start (lvl_start),
      .sum   (sum_in),
      .busy  (lvl_busy),
      .db    (lvl_db)
   );

   // a window-closing item is held until its level is ready
   assign rsp_ch.valid        = out_v_ff && !lvl_busy;
   assign rsp_ch.mixed_sample = out_mixed_ff;
   assign rsp_ch.level_valid  = out_lvalid_ff;
   assign rsp_ch.level_db     = out_lvalid_ff ? lvl_db : '0;

   // starting the level unit always parks a window-closing item at the output
   a_start_parks: assert property (@(posedge clock) disable iff (reset)
      lvl_start |=> (out_v_ff && out_lvalid_ff))
      else $error("level started without a parked window item");

   // the parked item stays put while the level unit works
   a_busy_holds: assert property (@(posedge clock) disable iff (reset)
      lvl_busy |-> (out_v_ff && !out_free))
      else $error("output moved while level unit busy");

   // a delivered window item leaves a fresh, empty window behind it
   a_window_reset: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && out_lvalid_ff) |-> (count_ff == '0 && sum_ff == '0))
      else $error("window not restarted after level item");

   // delivered levels stay within the meter range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.level_valid) |->
         (rsp_ch.level_db <= 13'sd0 && rsp_ch.level_db >= LEVEL_FLOOR))
      else $error("level out of range");

endmodule
